@@ rtl/core/vrq_pkg.sv @@
// vrq_pkg: types, codes and helpers shared by the record ring queue modules
// depends on nothing

package vrq_pkg;

    localparam int TS_W      = 64;
    localparam int LEN_W     = 11;
    localparam int ROFF_W    = 10;
    localparam int WORDS_W   = 14;
    localparam int FREE_W    = 17;
    localparam int MAX_LINE  = 1024;
    localparam int HDR_BYTES = 10;

    localparam logic [WORDS_W-1:0] RST_RING_WORDS = 14'd8192;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [TS_W-1:0]  ts;
        logic [LEN_W-1:0] len;
    } t_hdr;

    // header plus line, rounded up to whole 8-byte words
    function automatic logic [LEN_W-1:0] pad_len(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] s;
        s = {1'b0, len} + (LEN_W+1)'(HDR_BYTES + 7);
        return s[LEN_W-1:0] & ~(LEN_W'(7));
    endfunction

    // ring size in bytes for a register value, clamped to two words at least and to the store at most
    function automatic logic [31:0] ring_bytes(input logic [WORDS_W-1:0] words,
                                               input logic [31:0] store_words);
        logic [31:0] w;
        w = 32'(words);
        if (w < 32'd2) begin
            w = 32'd2;
        end else if (w > store_words) begin
            w = store_words;
        end
        return {w[28:0], 3'b000};
    endfunction

endpackage

@@ rtl/core/vrq_regs.sv @@
// vrq_regs: configuration register behind the apb-style port
// depends on vrq_pkg

module vrq_regs import vrq_pkg::*; #(
    parameter int RING_BYTES = 65536,
    parameter int FW         = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic              o_clear,
    output logic [FW-1:0]     o_size
);

    localparam logic [31:0] STORE_WORDS = 32'(RING_BYTES / 8);
    localparam logic        REG_RING_SIZE = 1'b0;

    logic [WORDS_W-1:0] r_ring_words;
    logic [FW-1:0]      r_size;
    logic               wr_hit;
    logic [31:0]        n_size;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_RING_SIZE);
    assign n_size = ring_bytes(pwdata[WORDS_W-1:0], STORE_WORDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_words <= RST_RING_WORDS;
            r_size       <= FW'(ring_bytes(RST_RING_WORDS, STORE_WORDS));
        end else if (wr_hit) begin
            r_ring_words <= pwdata[WORDS_W-1:0];
            r_size       <= n_size[FW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RING_SIZE) begin
            prdata = 32'(r_ring_words);
        end
    end

    // the clearing write already sees the new size
    assign o_clear = wr_hit;
    assign o_size  = wr_hit ? n_size[FW-1:0] : r_size;

endmodule

@@ rtl/core/vrq_line_ram.sv @@
// vrq_line_ram: byte-wide ring store for record line bytes
// depends on vrq_pkg

module vrq_line_ram import vrq_pkg::*; #(
    parameter int RING_BYTES = 65536,
    parameter int AW         = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [RING_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/core/vrq_hdr_fifo.sv @@
// vrq_hdr_fifo: header store, one entry per committed record, front read ahead
// depends on vrq_pkg

module vrq_hdr_fifo import vrq_pkg::*; #(
    parameter int HW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [HW-1:0] i_waddr,
    input  t_hdr          i_wdata,
    input  logic [HW-1:0] i_raddr,
    output t_hdr          o_rdata
);

    t_hdr r_mem [2**HW];
    t_hdr r_q;
    t_hdr r_byp_data;
    logic r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q        <= r_mem[i_raddr];
        r_byp_data <= i_wdata;
    end

    // same-cycle write to the entry being fetched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_q;

endmodule

@@ rtl/core/variable_record_ring_queue_core.sv @@
// variable_record_ring_queue_core: top level of the variable-length record ring queue
// depends on vrq_pkg, vrq_regs, vrq_line_ram, vrq_hdr_fifo

// Takes one item per clock and returns its result in the output register on the
// next cycle; the output register holds while o_valid waits for i_ready, and a
// new item is accepted whenever that register is empty or is being taken. The
// byte store takes one write and one read per cycle, and record headers live in
// a separate store read one entry ahead, so remove followed by read also runs at
// one item per cycle. Neither store is cleared after reset; a write to the ring
// size register empties the queue at once.

module variable_record_ring_queue_core import vrq_pkg::*; #(
    parameter int RING_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_data_byte,
    input  logic                i_byte_valid,
    input  logic                i_last,
    input  logic [TS_W-1:0]     i_timestamp,
    input  logic [ROFF_W-1:0]   i_read_offset,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [7:0]          o_read_byte,
    output logic [LEN_W-1:0]    o_record_length,
    output logic [TS_W-1:0]     o_record_timestamp,
    output logic [FREE_W-1:0]   o_free_bytes,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (RING_BYTES > 2) ? $clog2(RING_BYTES) : 1;
    localparam int FW = $clog2(RING_BYTES + 1);
    localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam int HW = (RING_BYTES / 16 > 2) ? $clog2(RING_BYTES / 16) : 1;
    localparam logic [31:0] RST_SIZE = ring_bytes(RST_RING_WORDS, 32'(RING_BYTES / 8));

    logic             cfg_clear;
    logic [FW-1:0]    cfg_size;

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [FW-1:0]    r_free, n_free;
    logic [LEN_W-1:0] r_open_len, n_open_len;
    logic             r_open_drop, n_open_drop;
    logic [HW-1:0]    r_wr, n_wr;
    logic [HW-1:0]    r_rd, n_rd;

    logic             r_out_v;
    t_status          r_o_status, n_status;
    logic             r_o_hit, n_hit;
    logic [LEN_W-1:0] r_o_len, n_len;
    logic [TS_W-1:0]  r_o_ts, n_ts;
    logic [FW-1:0]    r_o_free;

    logic             acc;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_q;
    logic             hdr_we;
    t_hdr             hdr_wdata;
    t_hdr             front;

    logic [SW-1:0]    size_s, free_s, head_s, tail_s;
    logic [SW-1:0]    pos_s, need_app, need_rm;
    logic [SW-1:0]    wsum, tsum, hsum, fsum, rsum;
    logic [SW-1:0]    wwrap, twrap, hwrap, rwrap, fclamp;
    logic             empty, take, fits, drop_n, commit_ok, hit;
    logic [LEN_W-1:0] len_n;
    logic [31:0]      free_ext;

    vrq_regs #(
        .RING_BYTES (RING_BYTES),
        .FW         (FW)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_clear (cfg_clear),
        .o_size  (cfg_size)
    );

    vrq_line_ram #(
        .RING_BYTES (RING_BYTES),
        .AW         (AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    vrq_hdr_fifo #(
        .HW (HW)
    ) u_hdr_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (hdr_we),
        .i_waddr (r_wr),
        .i_wdata (hdr_wdata),
        .i_raddr (n_rd),
        .o_rdata (front)
    );

    assign o_ready = !r_out_v || i_ready;
    assign acc     = i_valid && o_ready;

    // address and count arithmetic
    assign size_s = SW'(cfg_size);
    assign free_s = SW'(r_free);
    assign head_s = SW'(r_head);
    assign tail_s = SW'(r_tail);
    assign empty  = free_s >= size_s;

    assign take      = i_byte_valid && (r_open_len < LEN_W'(MAX_LINE));
    assign pos_s     = SW'(HDR_BYTES) + SW'(r_open_len);
    assign fits      = pos_s < free_s;
    assign len_n     = take ? r_open_len + LEN_W'(1) : r_open_len;
    assign drop_n    = r_open_drop || (take && !fits);
    assign need_app  = SW'(pad_len(len_n));
    assign commit_ok = !drop_n && (need_app <= free_s);

    assign wsum  = tail_s + pos_s;
    assign wwrap = (wsum >= size_s) ? wsum - size_s : wsum;
    assign tsum  = tail_s + need_app;
    assign twrap = (tsum >= size_s) ? tsum - size_s : tsum;

    assign need_rm = SW'(pad_len(front.len));
    assign hsum    = head_s + need_rm;
    assign hwrap   = (hsum >= size_s) ? hsum - size_s : hsum;
    assign fsum    = free_s + need_rm;
    assign fclamp  = (fsum > size_s) ? size_s : fsum;

    assign rsum  = head_s + SW'(HDR_BYTES) + SW'(i_read_offset);
    assign rwrap = (rsum >= size_s) ? rsum - size_s : rsum;
    assign hit   = {1'b0, i_read_offset} < front.len;

    assign ram_waddr = wwrap[AW-1:0];
    assign ram_raddr = rwrap[AW-1:0];
    assign hdr_wdata = '{ts: i_timestamp, len: len_n};

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_open_len  = r_open_len;
        n_open_drop = r_open_drop;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_status    = ST_OK;
        n_hit       = 1'b0;
        n_len       = '0;
        n_ts        = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        hdr_we      = 1'b0;
        if (cfg_clear) begin
            n_head      = '0;
            n_tail      = '0;
            n_free      = cfg_size;
            n_open_len  = '0;
            n_open_drop = 1'b0;
            n_wr        = '0;
            n_rd        = '0;
        end else if (acc) begin
            case (t_cmd'(i_cmd))
                CMD_APPEND: begin
                    ram_we      = take && fits;
                    n_open_len  = len_n;
                    n_open_drop = drop_n;
                    if (i_last) begin
                        n_open_len  = '0;
                        n_open_drop = 1'b0;
                        if (commit_ok) begin
                            hdr_we = 1'b1;
                            n_wr   = r_wr + HW'(1);
                            n_tail = twrap[AW-1:0];
                            n_free = FW'(free_s - need_app);
                        end else begin
                            n_status = ST_NO_SPACE;
                        end
                    end
                end
                CMD_READ: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_len  = front.len;
                        n_ts   = front.ts;
                        n_hit  = hit;
                        ram_re = hit;
                    end
                end
                CMD_REMOVE: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_rd   = r_rd + HW'(1);
                        n_head = hwrap[AW-1:0];
                        n_free = fclamp[FW-1:0];
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= RST_SIZE[FW-1:0];
            r_open_len  <= '0;
            r_open_drop <= 1'b0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_out_v     <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_open_len  <= n_open_len;
            r_open_drop <= n_open_drop;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            if (acc) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_o_status <= n_status;
            r_o_hit    <= n_hit;
            r_o_len    <= n_len;
            r_o_ts     <= n_ts;
            r_o_free   <= n_free;
        end
    end

    assign free_ext           = 32'(r_o_free);
    assign o_valid            = r_out_v;
    assign o_status           = r_o_status;
    assign o_read_byte        = r_o_hit ? ram_q : 8'd0;
    assign o_record_length    = r_o_len;
    assign o_record_timestamp = r_o_ts;
    assign o_free_bytes       = free_ext[FREE_W-1:0];

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking testbench for variable_record_ring_queue_core
// drives items and APB register writes, predicts each result and checks it field by field
// depends on vrq_pkg and the core RTL

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vrq_pkg::*;

    localparam int RING_BYTES_TB = 65536;
    localparam int STORE_WORDS = RING_BYTES_TB / 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] REG_RING_WORDS = 3'd0;

    typedef struct packed {
        t_status             status;
        logic [7:0]          rbyte;
        logic [LEN_W-1:0]    rlen;
        logic [TS_W-1:0]     rts;
        logic [FREE_W-1:0]   free;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_cmd = '0;
    logic [7:0]          i_data_byte = '0;
    logic                i_byte_valid = 1'b0;
    logic                i_last = 1'b0;
    logic [TS_W-1:0]     i_timestamp = '0;
    logic [ROFF_W-1:0]   i_read_offset = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [1:0]          o_status;
    logic [7:0]          o_read_byte;
    logic [LEN_W-1:0]    o_record_length;
    logic [TS_W-1:0]     o_record_timestamp;
    logic [FREE_W-1:0]   o_free_bytes;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    variable_record_ring_queue_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_data_byte        (i_data_byte),
        .i_byte_valid       (i_byte_valid),
        .i_last             (i_last),
        .i_timestamp        (i_timestamp),
        .i_read_offset      (i_read_offset),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_read_byte        (o_read_byte),
        .o_record_length    (o_record_length),
        .o_record_timestamp (o_record_timestamp),
        .o_free_bytes       (o_free_bytes),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // queue model state
    bit [7:0]            ring_mem [RING_BYTES_TB];
    int unsigned         head_pos;
    int unsigned         tail_pos;
    int unsigned         free_cnt;
    int unsigned         open_len;
    bit                  open_drop;
    logic [WORDS_W-1:0]  ring_words_cfg;

    t_result             pending_results [$];
    int                  error_count = 0;
    int                  gap_pct = 0;
    int                  stall_pct = 0;
    int                  hold_count = 0;
    int                  n_items = 0;
    int                  n_reads = 0;
    int                  n_removes = 0;
    int                  n_empty_hits = 0;
    int                  n_committed = 0;
    int                  n_dropped = 0;
    int                  n_configs = 0;

    function automatic int unsigned ring_span();
        int unsigned w;
        w = 32'(ring_words_cfg);
        if (w < 2) begin
            w = 2;
        end
        if (w > STORE_WORDS) begin
            w = STORE_WORDS;
        end
        return w * 8;
    endfunction

    function automatic int unsigned rec_span(input int unsigned len);
        return (HDR_BYTES + len + 7) & ~32'd7;
    endfunction

    function automatic logic [7:0] mem_rd(input int unsigned addr);
        return ring_mem[addr % ring_span()];
    endfunction

    function automatic void mem_wr(input int unsigned addr, input logic [7:0] v);
        ring_mem[addr % ring_span()] = v;
    endfunction

    function automatic bit queue_empty();
        return free_cnt >= ring_span();
    endfunction

    function automatic int unsigned front_len();
        return 32'({mem_rd(head_pos + 9), mem_rd(head_pos + 8)});
    endfunction

    function automatic void clear_queue_model();
        head_pos = 0;
        tail_pos = 0;
        free_cnt = ring_span();
        open_len = 0;
        open_drop = 1'b0;
    endfunction

    function automatic t_result predict_queue_step(input logic [1:0] cmd, input logic [7:0] data,
                                                   input bit bv, input bit last,
                                                   input logic [63:0] ts,
                                                   input logic [9:0] roff);
        t_result r;
        bit empty;
        int unsigned pos;
        int unsigned need;
        int unsigned len;
        r = '0;
        r.status = ST_OK;
        empty = queue_empty();
        case (cmd)
            CMD_APPEND: begin
                if (bv || last) begin
                    n_items++;
                end
                if (bv && open_len < MAX_LINE) begin
                    pos = HDR_BYTES + open_len;
                    if (pos + 1 > free_cnt) begin
                        open_drop = 1'b1;
                    end else begin
                        mem_wr(tail_pos + pos, data);
                    end
                    open_len++;
                end
                if (last) begin
                    need = rec_span(open_len);
                    if (open_drop || need > free_cnt) begin
                        r.status = ST_NO_SPACE;
                        n_dropped++;
                    end else begin
                        for (int i = 0; i < 8; i++) begin
                            mem_wr(tail_pos + i, ts[8*i +: 8]);
                        end
                        mem_wr(tail_pos + 8, open_len[7:0]);
                        mem_wr(tail_pos + 9, open_len[15:8]);
                        tail_pos = (tail_pos + need) % ring_span();
                        free_cnt -= need;
                        n_committed++;
                    end
                    open_len = 0;
                    open_drop = 1'b0;
                end
            end
            CMD_READ, CMD_REMOVE: begin
                n_items++;
                if (cmd == CMD_READ) begin
                    n_reads++;
                end else begin
                    n_removes++;
                end
                if (empty) begin
                    r.status = ST_EMPTY;
                    n_empty_hits++;
                end else begin
                    len = front_len();
                    if (cmd == CMD_READ) begin
                        for (int i = 0; i < 8; i++) begin
                            r.rts[8*i +: 8] = mem_rd(head_pos + i);
                        end
                        r.rlen = len[LEN_W-1:0];
                        if (32'(roff) < len) begin
                            r.rbyte = mem_rd(head_pos + HDR_BYTES + 32'(roff));
                        end
                    end else begin
                        need = rec_span(len);
                        head_pos = (head_pos + need) % ring_span();
                        free_cnt += need;
                        if (free_cnt > ring_span()) begin
                            free_cnt = ring_span();
                        end
                    end
                end
            end
            default: ;
        endcase
        r.free = free_cnt[FREE_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item outstanding, status 0x%0h", $time, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("read_byte", 64'(want.rbyte), 64'(o_read_byte));
                check_field("record_length", 64'(want.rlen), 64'(o_record_length));
                check_field("record_timestamp", want.rts, o_record_timestamp);
                check_field("free_bytes", 64'(want.free), 64'(o_free_bytes));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_count > 0) begin
            i_ready <= 1'b0;
            hold_count <= hold_count - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand_ts();
        return {$urandom, $urandom};
    endfunction

    task automatic set_idle(input int send_gap, input int rx_stall);
        gap_pct = send_gap;
        stall_pct = rx_stall;
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input bit bv,
                             input bit last, input logic [63:0] ts, input logic [9:0] roff);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 20) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= data;
        i_byte_valid <= bv;
        i_last <= last;
        i_timestamp <= ts;
        i_read_offset <= roff;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_queue_step(cmd, data, bv, last, ts, roff));
    endtask

    task automatic send_append(input logic [7:0] data, input bit bv, input bit last,
                               input logic [63:0] ts);
        send_item(CMD_APPEND, data, bv, last, ts, 10'($urandom_range(1023)));
    endtask

    task automatic send_read(input logic [9:0] roff);
        send_item(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), rand_ts(), roff);
    endtask

    task automatic send_remove();
        send_item(CMD_REMOVE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), rand_ts(), 10'($urandom_range(1023)));
    endtask

    task automatic poke_front();
        int unsigned len;
        len = queue_empty() ? 0 : front_len();
        case ($urandom_range(3))
            0, 1: begin
                if (len > 0 && $urandom_range(3) != 0) begin
                    send_read(10'($urandom_range(len - 1)));
                end else begin
                    send_read(10'($urandom_range(1023)));
                end
            end
            2: send_read(10'(len));
            default: send_remove();
        endcase
    endtask

    // one line of len bytes; the closing item either carries the last byte or is empty
    task automatic append_record(input int len, input bit mixed);
        bit tail_carries;
        tail_carries = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if (mixed && $urandom_range(15) == 0) begin
                poke_front();
            end
            if (mixed && $urandom_range(15) == 0) begin
                send_append(8'($urandom_range(255)), 1'b0, 1'b0, rand_ts());
            end
            send_append(8'($urandom_range(255)), 1'b1, tail_carries && i == len - 1,
                        rand_ts());
        end
        if (!tail_carries) begin
            send_append(8'($urandom_range(255)), 1'b0, 1'b1, rand_ts());
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_ring_words(input logic [WORDS_W-1:0] words);
        logic [31:0] rd;
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_RING_WORDS;
        pwdata <= 32'(words);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        ring_words_cfg = words;
        clear_queue_model();
        n_configs++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(words)) begin
            $display("%0t: ring_size_words readback mismatch: expected 0x%0h, actual 0x%0h",
                     $time, 32'(words), rd);
            error_count++;
        end
    endtask

    function automatic int pick_len(input int max_len);
        if ($urandom_range(3) == 0) begin
            return $urandom_range(max_len);
        end
        return $urandom_range(max_len / 4);
    endfunction

    task automatic run_traffic(input int n_target, input int max_len);
        int start;
        int pick;
        start = n_items;
        while (n_items - start < n_target) begin
            pick = $urandom_range(19);
            if (pick < 9) begin
                append_record(pick_len(max_len), 1'b1);
            end else if (pick < 14) begin
                poke_front();
            end else if (pick < 17) begin
                send_remove();
            end else if (pick == 17) begin
                send_item(CMD_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), rand_ts(), 10'($urandom_range(1023)));
            end else begin
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), rand_ts(),
                          10'($urandom_range(1023)));
            end
        end
    endtask

    task automatic test_directed_basics();
        send_read(10'd0);
        send_remove();
        send_item(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, '1, '1);
        send_append(8'h5A, 1'b0, 1'b0, '1);
        send_append(8'h00, 1'b0, 1'b1, '1);
        send_read(10'd0);
        send_remove();
        send_append(8'h00, 1'b1, 1'b0, rand_ts());
        send_append(8'hFF, 1'b1, 1'b0, rand_ts());
        send_append(8'hA5, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_append(8'h3C, 1'b1, 1'b1, '0);
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'd2);
        send_read(10'd3);
        send_read(10'd1023);
        send_remove();
        send_read(10'd0);
        send_remove();
        send_remove();
    endtask

    task automatic test_truncation();
        append_record(MAX_LINE + 6, 1'b0);
        send_read(10'd0);
        send_read(10'd1023);
        send_remove();
    endtask

    task automatic test_register_extremes();
        write_ring_words(14'd0);
        append_record(6, 1'b0);
        append_record(0, 1'b0);
        send_read(10'd5);
        send_read(10'd6);
        send_remove();
        send_read(10'd0);
        append_record(7, 1'b0);
        write_ring_words(14'd1);
        append_record(2, 1'b0);
        send_read(10'd1);
        write_ring_words(14'd3);
        repeat (3) begin
            append_record(6, 1'b0);
            send_read(10'd0);
            send_read(10'd5);
            send_remove();
        end
        write_ring_words(14'h3FFF);
        append_record(1, 1'b0);
        send_read(10'd0);
        send_remove();
    endtask

    task automatic test_fill_and_wrap();
        write_ring_words(14'd37);
        repeat (10) append_record(20, 1'b0);
        repeat (3) send_remove();
        repeat (4) append_record(20, 1'b1);
        while (!queue_empty()) begin
            send_read(10'($urandom_range(24)));
            send_remove();
        end
    endtask

    task automatic test_backpressure();
        write_ring_words(14'd64);
        hold_count <= 400;
        repeat (12) begin
            append_record(3, 1'b0);
            send_read(10'($urandom_range(3)));
        end
        wait_drained();
        repeat (14) send_remove();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        set_idle(0, 0);
        write_ring_words(14'd2);
        run_traffic(60, 8);
        set_idle(63, 0);
        write_ring_words(14'd37);
        run_traffic(130, 60);
        set_idle(0, 63);
        write_ring_words(14'd300);
        run_traffic(130, 200);
        set_idle(13, 13);
        write_ring_words(14'd8192);
        run_traffic(130, 120);
    endtask

    initial begin
        int guard;
        ring_words_cfg = RST_RING_WORDS;
        clear_queue_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_basics();
        test_truncation();
        test_register_extremes();
        test_fill_and_wrap();
        test_backpressure();
        test_random_traffic();
        i_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count += pending_results.size();
        end
        $display("covered %0d items over %0d ring sizes: %0d records committed, %0d dropped",
                 n_items, n_configs + 1, n_committed, n_dropped);
        $display("%0d reads, %0d removes, %0d on an empty queue, %0d errors",
                 n_reads, n_removes, n_empty_hits, error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
